// File: rtl/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

  // heap geometry
  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int NODE_W   = $clog2(CAPACITY + 1);
  localparam int LEVELS   = NODE_W;
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int PA_W     = ($clog2(CAPACITY) > 1) ? $clog2(CAPACITY) - 1 : 1;

  // words that travel down the chain (toward the leaves)
  typedef enum logic [1:0] {
    DN_SEEK_INS,
    DN_SEEK_GET,
    DN_SIFT,
    DN_WB
  } dn_op_t;

  // words that travel up the chain (toward the root)
  typedef enum logic [1:0] {
    UP_SIFT,
    UP_WB,
    UP_GET
  } up_op_t;

  typedef struct packed {
    logic              valid;
    dn_op_t            op;
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } dn_link_t;

  typedef struct packed {
    logic              valid;
    up_op_t            op;
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0]  key;
  } up_link_t;

  // one level's access to its pair of key RAMs
  typedef struct packed {
    logic [PA_W-1:0]  rd_addr;
    logic [PA_W-1:0]  wr_addr;
    logic             we_l;
    logic             we_r;
    logic [KEY_W-1:0] wr_data;
  } mem_req_t;

  // true when a must sit below b under the current order
  function automatic logic ranks_after(input logic ord, input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
    return ord ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

// File: rtl/bhpq_ram.sv
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/bhpq_cell.sv
`default_nettype none

module bhpq_cell import bhpq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [LVL_W-1:0]  level_i,
  input  wire logic              order_i,
  input  wire logic [NODE_W-1:0] fill_i,
  input  wire dn_link_t          dn_i,
  output dn_link_t               dn_o,
  input  wire up_link_t          up_i,
  output up_link_t               up_o,
  output logic                   busy_o,
  output mem_req_t               mem_o,
  input  wire logic [KEY_W-1:0]  rd_l_i,
  input  wire logic [KEY_W-1:0]  rd_r_i
);

  typedef enum logic [1:0] {
    K_SIFT_DN,
    K_SIFT_UP,
    K_GET
  } kind_t;

  logic              st_vld_r, st_vld_nxt;
  kind_t             st_kind_r, st_kind_nxt;
  logic [NODE_W-1:0] st_node_r, st_node_nxt;
  logic [KEY_W-1:0]  st_key_r, st_key_nxt;
  dn_link_t          dn_r, dn_nxt;
  up_link_t          up_r, up_nxt;

  logic [LVL_W-1:0]  lvl_m1;
  logic [NODE_W-1:0] lvl_mask;
  logic              in_mine;
  logic [NODE_W-1:0] rd_pair_node;
  logic [NODE_W-1:0] rd_pair_idx;

  logic              has_right;
  logic              pick_r;
  logic [KEY_W-1:0]  pick_key;
  logic              dn_swap;
  logic [NODE_W-1:0] child;
  logic              has_gc;
  logic [KEY_W-1:0]  par_key;
  logic              up_swap;
  logic [KEY_W-1:0]  own_key;

  logic              wr_en;
  logic              wr_side;
  logic [NODE_W-1:0] wr_pair_node;
  logic [NODE_W-1:0] wr_pair_idx;
  logic [KEY_W-1:0]  wr_data;

  // locate this level: pair index is the node's parent with the level bit dropped
  assign lvl_m1   = level_i - LVL_W'(1);
  assign lvl_mask = (NODE_W'(1) << lvl_m1) - NODE_W'(1);
  assign in_mine  = (dn_i.node >> level_i) == NODE_W'(1);

  // pick the pair to read from the incoming word
  always_comb begin
    if (up_i.valid) begin
      rd_pair_node = up_i.node >> 2;
    end else if (dn_i.op == DN_SIFT) begin
      rd_pair_node = dn_i.node;
    end else begin
      rd_pair_node = dn_i.node >> 1;
    end
  end

  assign rd_pair_idx = rd_pair_node & lvl_mask;

  // sift-down decision over the two children just read
  assign has_right = {st_node_r, 1'b1} <= {1'b0, fill_i};
  assign pick_r    = has_right && !ranks_after(order_i, rd_r_i, rd_l_i);
  assign pick_key  = pick_r ? rd_r_i : rd_l_i;
  assign dn_swap   = ranks_after(order_i, st_key_r, pick_key);
  assign child     = {st_node_r[NODE_W-2:0], pick_r};
  assign has_gc    = {child, 1'b0} <= {1'b0, fill_i};

  // sift-up decision against the parent just read
  assign par_key = st_node_r[1] ? rd_r_i : rd_l_i;
  assign up_swap = ranks_after(order_i, par_key, st_key_r);

  // plain fetch of one of this level's entries
  assign own_key = st_node_r[0] ? rd_r_i : rd_l_i;

  always_comb begin
    st_vld_nxt   = 1'b0;
    st_kind_nxt  = st_kind_r;
    st_node_nxt  = st_node_r;
    st_key_nxt   = st_key_r;
    dn_nxt       = '0;
    up_nxt       = '0;
    wr_en        = 1'b0;
    wr_side      = 1'b0;
    wr_pair_node = '0;
    wr_data      = '0;

    // finish the step whose RAM data is now back
    if (st_vld_r) begin
      unique case (st_kind_r)
        K_SIFT_DN: begin
          up_nxt = '{valid: 1'b1, op: UP_WB, node: st_node_r,
                     key: dn_swap ? pick_key : st_key_r};
          if (has_gc) begin
            dn_nxt = '{valid: 1'b1, op: DN_SIFT, node: child,
                       key: dn_swap ? st_key_r : pick_key};
          end else begin
            wr_en        = 1'b1;
            wr_side      = pick_r;
            wr_pair_node = st_node_r;
            wr_data      = dn_swap ? st_key_r : pick_key;
          end
        end
        K_SIFT_UP: begin
          dn_nxt = '{valid: 1'b1, op: DN_WB, node: st_node_r,
                     key: up_swap ? par_key : st_key_r};
          up_nxt = '{valid: 1'b1, op: UP_SIFT, node: st_node_r >> 1,
                     key: up_swap ? st_key_r : par_key};
        end
        K_GET: begin
          up_nxt = '{valid: 1'b1, op: UP_GET, node: st_node_r, key: own_key};
        end
        default: begin
        end
      endcase
    end

    // take a word from the level above
    if (dn_i.valid) begin
      unique case (dn_i.op)
        DN_SEEK_INS: begin
          if (in_mine) begin
            up_nxt = '{valid: 1'b1, op: UP_SIFT, node: dn_i.node, key: dn_i.key};
          end else begin
            dn_nxt = dn_i;
          end
        end
        DN_SEEK_GET: begin
          if (in_mine) begin
            st_vld_nxt  = 1'b1;
            st_kind_nxt = K_GET;
            st_node_nxt = dn_i.node;
          end else begin
            dn_nxt = dn_i;
          end
        end
        DN_SIFT: begin
          st_vld_nxt  = 1'b1;
          st_kind_nxt = K_SIFT_DN;
          st_node_nxt = dn_i.node;
          st_key_nxt  = dn_i.key;
        end
        DN_WB: begin
          wr_en        = 1'b1;
          wr_side      = dn_i.node[0];
          wr_pair_node = dn_i.node >> 1;
          wr_data      = dn_i.key;
        end
      endcase
    end

    // take a word from the level below
    if (up_i.valid) begin
      unique case (up_i.op)
        UP_SIFT: begin
          st_vld_nxt  = 1'b1;
          st_kind_nxt = K_SIFT_UP;
          st_node_nxt = up_i.node;
          st_key_nxt  = up_i.key;
        end
        UP_WB: begin
          wr_en        = 1'b1;
          wr_side      = up_i.node[0];
          wr_pair_node = up_i.node >> 1;
          wr_data      = up_i.key;
        end
        UP_GET: begin
          up_nxt = up_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_pair_idx = wr_pair_node & lvl_mask;

  always_comb begin
    mem_o.rd_addr = rd_pair_idx[PA_W-1:0];
    mem_o.wr_addr = wr_pair_idx[PA_W-1:0];
    mem_o.we_l    = wr_en && !wr_side;
    mem_o.we_r    = wr_en && wr_side;
    mem_o.wr_data = wr_data;
  end

  // hold the step in flight and the words handed to the neighbors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r   <= 1'b0;
      dn_r.valid <= 1'b0;
      up_r.valid <= 1'b0;
    end else begin
      st_vld_r   <= st_vld_nxt;
      dn_r.valid <= dn_nxt.valid;
      up_r.valid <= up_nxt.valid;
    end
    st_kind_r <= st_kind_nxt;
    st_node_r <= st_node_nxt;
    st_key_r  <= st_key_nxt;
    dn_r.op   <= dn_nxt.op;
    dn_r.node <= dn_nxt.node;
    dn_r.key  <= dn_nxt.key;
    up_r.op   <= up_nxt.op;
    up_r.node <= up_nxt.node;
    up_r.key  <= up_nxt.key;
  end

  assign dn_o   = dn_r;
  assign up_o   = up_r;
  assign busy_o = st_vld_r;

endmodule

`default_nettype wire

// File: rtl/binary_heap_priority_queue_core.sv
// Operation: one word at a time; the next word is taken the cycle after the result is
//   published, and a result is published only once the output register is free or being taken.
// Reset (synchronous, rst_n low): heap empties, order goes smallest-first, keys are kept.
`default_nettype none

module binary_heap_priority_queue_core import bhpq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_func,
  input  wire logic [KEY_W-1:0]  in_key_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [KEY_W-1:0]  out_key_out,
  output logic                   out_key_valid,
  output logic                   out_empty_res,
  output logic      [NODE_W-1:0] out_entry_count,
  output logic      [1:0]        out_status,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_order_mode
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DRAIN
  } state_t;

  typedef enum logic {
    FN_INSERT,
    FN_EXTRACT
  } func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY
  } status_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] fill_r, fill_nxt;
  logic [KEY_W-1:0]  root_r, root_nxt;
  logic              order_r, order_nxt;
  dn_link_t          dn_top_r, dn_top_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic              res_kv_r, res_kv_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic              out_kv_r, out_kv_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic [NODE_W-1:0] out_count_r, out_count_nxt;
  status_t           out_status_r, out_status_nxt;

  dn_link_t          dn_link [1:LEVELS];
  up_link_t          up_link [1:LEVELS];
  logic              busy    [1:LEVELS-1];
  mem_req_t          mem_req [1:LEVELS-1];
  logic [KEY_W-1:0]  rd_l    [1:LEVELS-1];
  logic [KEY_W-1:0]  rd_r    [1:LEVELS-1];

  logic              quiet;
  logic              root_swap;

  assign dn_link[1]      = dn_top_r;
  assign up_link[LEVELS] = '0;

  // one cell and one pair of key RAMs for every level below the root
  for (genvar k = 1; k < LEVELS; k++) begin : g_lvl
    localparam int HALF = 1 << (k - 1);
    localparam int FILL = (CAPACITY >> 1) - HALF + 1;
    localparam int DEP  = (HALF < FILL) ? HALF : FILL;
    localparam int RAW  = (DEP > 1) ? $clog2(DEP) : 1;

    bhpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .level_i (LVL_W'(k)),
      .order_i (order_r),
      .fill_i  (fill_r),
      .dn_i    (dn_link[k]),
      .dn_o    (dn_link[k+1]),
      .up_i    (up_link[k+1]),
      .up_o    (up_link[k]),
      .busy_o  (busy[k]),
      .mem_o   (mem_req[k]),
      .rd_l_i  (rd_l[k]),
      .rd_r_i  (rd_r[k])
    );

    bhpq_ram #(.WIDTH(KEY_W), .DEPTH(DEP)) u_ram_l (
      .clk   (clk),
      .we    (mem_req[k].we_l),
      .waddr (mem_req[k].wr_addr[RAW-1:0]),
      .wdata (mem_req[k].wr_data),
      .raddr (mem_req[k].rd_addr[RAW-1:0]),
      .rdata (rd_l[k])
    );

    bhpq_ram #(.WIDTH(KEY_W), .DEPTH(DEP)) u_ram_r (
      .clk   (clk),
      .we    (mem_req[k].we_r),
      .waddr (mem_req[k].wr_addr[RAW-1:0]),
      .wdata (mem_req[k].wr_data),
      .raddr (mem_req[k].rd_addr[RAW-1:0]),
      .rdata (rd_r[k])
    );
  end

  // the chain is quiet when no word and no step is in flight
  always_comb begin
    quiet = !dn_top_r.valid;
    for (int k = 1; k <= LEVELS; k++) begin
      if (dn_link[k].valid || up_link[k].valid) begin
        quiet = 1'b0;
      end
    end
    for (int k = 1; k < LEVELS; k++) begin
      if (busy[k]) begin
        quiet = 1'b0;
      end
    end
  end

  assign root_swap = ranks_after(order_r, root_r, up_link[1].key);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    root_nxt       = root_r;
    order_nxt      = order_r;
    dn_top_nxt     = '0;
    res_key_nxt    = res_key_r;
    res_kv_nxt     = res_kv_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_key_nxt    = out_key_r;
    out_kv_nxt     = out_kv_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;

    // latch the order bit
    if (cfg_valid) begin
      order_nxt = cfg_order_mode;
    end

    // drop the result word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // act as the root cell for words coming up from level one
    if (up_link[1].valid) begin
      unique case (up_link[1].op)
        UP_SIFT: begin
          root_nxt   = root_swap ? up_link[1].key : root_r;
          dn_top_nxt = '{valid: 1'b1, op: DN_WB, node: up_link[1].node,
                         key: root_swap ? root_r : up_link[1].key};
        end
        UP_WB: begin
          root_nxt = up_link[1].key;
        end
        UP_GET: begin
          if (fill_r >= NODE_W'(2)) begin
            dn_top_nxt = '{valid: 1'b1, op: DN_SIFT, node: NODE_W'(1),
                           key: up_link[1].key};
          end else begin
            root_nxt = up_link[1].key;
          end
          state_nxt = S_DRAIN;
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_key_nxt    = '0;
          res_kv_nxt     = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DRAIN;
          if (in_func == FN_INSERT) begin
            if (fill_r == NODE_W'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
            end else begin
              fill_nxt = fill_r + NODE_W'(1);
              if (fill_r == '0) begin
                root_nxt = in_key_in;
              end else begin
                dn_top_nxt = '{valid: 1'b1, op: DN_SEEK_INS, node: fill_r + NODE_W'(1),
                               key: in_key_in};
              end
            end
          end else begin
            if (fill_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              res_key_nxt = root_r;
              res_kv_nxt  = 1'b1;
              fill_nxt    = fill_r - NODE_W'(1);
              if (fill_r >= NODE_W'(2)) begin
                dn_top_nxt = '{valid: 1'b1, op: DN_SEEK_GET, node: fill_r, key: '0};
                state_nxt  = S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
      end
      S_DRAIN: begin
        // publish once the heap has settled and the output register is free
        if (quiet && (!out_valid_r || out_ready)) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = res_key_r;
          out_kv_nxt     = res_kv_r;
          out_empty_nxt  = (fill_r == '0);
          out_count_nxt  = fill_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state, heap control and the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      fill_r         <= '0;
      order_r        <= 1'b0;
      dn_top_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      fill_r         <= fill_nxt;
      order_r        <= order_nxt;
      dn_top_r.valid <= dn_top_nxt.valid;
      out_valid_r    <= out_valid_nxt;
    end
    dn_top_r.op   <= dn_top_nxt.op;
    dn_top_r.node <= dn_top_nxt.node;
    dn_top_r.key  <= dn_top_nxt.key;
    root_r        <= root_nxt;
    res_key_r     <= res_key_nxt;
    res_kv_r      <= res_kv_nxt;
    res_status_r  <= res_status_nxt;
    out_key_r     <= out_key_nxt;
    out_kv_r      <= out_kv_nxt;
    out_empty_r   <= out_empty_nxt;
    out_count_r   <= out_count_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_key_out     = out_key_r;
  assign out_key_valid   = out_kv_r;
  assign out_empty_res   = out_empty_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

// File: tb/bhpq_checker.sv
`timescale 1ns / 100ps

package heap_tb_pkg;

  // operation codes carried by in_func
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // order register values
  localparam logic ORDER_MIN = 1'b0;
  localparam logic ORDER_MAX = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

module bhpq_checker
  import bhpq_pkg::*;
  import heap_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_func,
  input  logic [KEY_W-1:0]  in_key_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KEY_W-1:0]  out_key_out,
  input  logic              out_key_valid,
  input  logic              out_empty_res,
  input  logic [NODE_W-1:0] out_entry_count,
  input  logic [1:0]        out_status,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_order_mode,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              key_valid;
    logic              empty;
    logic [NODE_W-1:0] count;
    logic [1:0]        status;
  } heap_result_t;

  // shadow heap, 1-based node numbering as in the array layout
  logic [KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned      heap_fill = 0;
  logic             heap_order = ORDER_MIN;
  heap_result_t     expected_q [$];
  int               mismatches = 0;
  int               queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  // true when a must sit below b under the current order
  function automatic logic sits_below(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return (heap_order == ORDER_MAX) ? (a < b) : (a > b);
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] seen);
    mismatches = mismatches + 1;
    if (mismatches <= 40)
      $display("mismatch: %s expected %0h got %0h at %0t", what, want, seen, $time);
  endtask

  // apply one operation to the shadow heap and work out its result word
  task automatic apply_op(input logic func, input logic [KEY_W-1:0] key,
                          output heap_result_t res);
    int unsigned      node;
    int unsigned      up;
    int unsigned      left;
    int unsigned      pick;
    logic [KEY_W-1:0] tmp;
    res        = '0;
    res.status = STATUS_OK;
    if (func == FUNC_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        heap_keys[heap_fill] = key;
        heap_fill = heap_fill + 1;
        // sift up through every level to the root
        node = heap_fill;
        while (node > 1) begin
          up = node / 2;
          if (sits_below(heap_keys[up-1], heap_keys[node-1])) begin
            tmp = heap_keys[up-1];
            heap_keys[up-1] = heap_keys[node-1];
            heap_keys[node-1] = tmp;
          end
          node = up;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.key       = heap_keys[0];
        res.key_valid = 1'b1;
        heap_fill = heap_fill - 1;
        heap_keys[0] = heap_keys[heap_fill];
        // sift down along the preferred child to a leaf; ties go right
        node = 1;
        while (node * 2 <= heap_fill) begin
          left = node * 2;
          if (left + 1 <= heap_fill)
            pick = sits_below(heap_keys[left], heap_keys[left-1]) ? left : left + 1;
          else
            pick = left;
          if (sits_below(heap_keys[node-1], heap_keys[pick-1])) begin
            tmp = heap_keys[node-1];
            heap_keys[node-1] = heap_keys[pick-1];
            heap_keys[pick-1] = tmp;
          end
          node = pick;
        end
      end
    end
    res.empty = (heap_fill == 0);
    res.count = heap_fill[NODE_W-1:0];
  endtask

  // watch all three channels; compare results before predicting new ones
  always @(posedge clk) begin : watch
    heap_result_t want;
    heap_result_t made;
    if (!rst_n) begin
      heap_fill  = 0;
      heap_order = ORDER_MIN;
      expected_q.delete();
      queued = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word", '0, out_key_out);
        end else begin
          want = expected_q.pop_front();
          if (out_key_out !== want.key)
            report_mismatch("key_out", want.key, out_key_out);
          if (out_key_valid !== want.key_valid)
            report_mismatch("key_valid", KEY_W'(want.key_valid), KEY_W'(out_key_valid));
          if (out_empty_res !== want.empty)
            report_mismatch("empty_res", KEY_W'(want.empty), KEY_W'(out_empty_res));
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", KEY_W'(want.count), KEY_W'(out_entry_count));
          if (out_status !== want.status)
            report_mismatch("status", KEY_W'(want.status), KEY_W'(out_status));
        end
      end
      if (cfg_valid && cfg_ready)
        heap_order = cfg_order_mode;
      if (in_valid && in_ready) begin
        apply_op(in_func, in_key_in, made);
        expected_q.push_back(made);
      end
      queued = expected_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bhpq_pkg::*;
  import heap_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAD   = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_func;
  logic [KEY_W-1:0]  in_key_in;
  logic              out_valid;
  logic              out_ready;
  logic [KEY_W-1:0]  out_key_out;
  logic              out_key_valid;
  logic              out_empty_res;
  logic [NODE_W-1:0] out_entry_count;
  logic [1:0]        out_status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_order_mode;
  logic              no_idle = 1'b0;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;

  always #5 clk = ~clk;

  binary_heap_priority_queue_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key_in       (in_key_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_out     (out_key_out),
    .out_key_valid   (out_key_valid),
    .out_empty_res   (out_empty_res),
    .out_entry_count (out_entry_count),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_order_mode  (cfg_order_mode)
  );

  bhpq_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key_in       (in_key_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_out     (out_key_out),
    .out_key_valid   (out_key_valid),
    .out_empty_res   (out_empty_res),
    .out_entry_count (out_entry_count),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_order_mode  (cfg_order_mode),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: stall a random number of cycles before taking each word
  initial begin : sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic func, input logic [KEY_W-1:0] key);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_key_in <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait out every pending result, then wait out the DRAIN_PAD padding
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_order(input logic mode);
    cfg_valid      <= 1'b1;
    cfg_order_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random mix; insert_pct steers the heap toward full or toward empty
  task automatic run_random(input int count, input int insert_pct);
    logic             func;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0)
        no_idle <= ($urandom_range(0, 3) == 0);
      func = ($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
      case ($urandom_range(0, 9))
        0:       key = '0;
        1:       key = '1;
        2, 3, 4: key = $urandom_range(0, 7);
        default: key = $urandom;
      endcase
      send_word(func, key);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_INSERT;
    in_key_in      = '0;
    cfg_valid      = 1'b0;
    cfg_order_mode = ORDER_MIN;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest-first: empty extract, extremes, equal keys
    write_order(ORDER_MIN);
    send_word(FUNC_EXTRACT, 32'hDEAD_BEEF);
    send_word(FUNC_INSERT, 32'hFFFF_FFFF);
    send_word(FUNC_INSERT, 32'h0000_0000);
    send_word(FUNC_INSERT, 32'h8000_0000);
    send_word(FUNC_INSERT, 32'h0000_0007);
    send_word(FUNC_INSERT, 32'h0000_0007);
    send_word(FUNC_INSERT, 32'h0000_0007);
    send_word(FUNC_INSERT, 32'h0000_0001);
    send_word(FUNC_EXTRACT, 32'h0000_0000);
    send_word(FUNC_EXTRACT, 32'hFFFF_FFFF);
    send_word(FUNC_EXTRACT, 32'h0000_0000);
    send_word(FUNC_EXTRACT, 32'h0000_0000);
    settle();

    // largest-first on a heap built under the other order
    write_order(ORDER_MAX);
    send_word(FUNC_INSERT, 32'h7FFF_FFFF);
    send_word(FUNC_INSERT, 32'h0000_0003);
    send_word(FUNC_INSERT, 32'h0000_0003);
    for (int i = 0; i < 7; i++)
      send_word(FUNC_EXTRACT, 32'h5555_AAAA);
    settle();

    // random phases across both orders, filling and draining
    write_order(ORDER_MAX);
    run_random(350, 85);
    settle();
    write_order(ORDER_MIN);
    run_random(350, 50);
    settle();
    write_order(ORDER_MIN);
    run_random(350, 15);
    settle();
    write_order(ORDER_MAX);
    run_random(350, 60);
    settle();
    write_order(ORDER_MIN);
    run_random(350, 30);
    settle();

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/bhpq_cell.sv
rtl/binary_heap_priority_queue_core.sv
tb/bhpq_checker.sv
tb/testbench.sv
